>>> rtl/tksd_pkg.sv
package tksd_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } tksd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] key_code;
  } tksd_out_t;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;

  localparam logic [2:0] ST_KEY   = 3'd0;
  localparam logic [2:0] ST_NONE  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_UNK   = 3'd4;
  localparam logic [2:0] ST_ERR   = 3'd5;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_UTF8  = 8'hC2;
  localparam logic [7:0] CH_POUND = 8'hA3;
  localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

  localparam logic [11:0] CODE_GBP = 12'h C00;
  localparam logic [11:0] CODE_FN  = 12'h200;

  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // final byte after ESC [
  function automatic logic [11:0] final_code(input logic [7:0] b);
    case (b)
      "A": final_code = 12'h102;
      "B": final_code = 12'h104;
      "C": final_code = 12'h101;
      "D": final_code = 12'h108;
      "H": final_code = 12'h118;
      "F": final_code = 12'h111;
      default: final_code = 12'h000;
    endcase
  endfunction

  // digit before '~'
  function automatic logic [11:0] tilde_code(input logic [7:0] d);
    case (d)
      "1": tilde_code = 12'h118;
      "2": tilde_code = 12'h121;
      "3": tilde_code = 12'h122;
      "4": tilde_code = 12'h111;
      "5": tilde_code = 12'h112;
      "6": tilde_code = 12'h114;
      default: tilde_code = 12'h000;
    endcase
  endfunction

  // function key number from two digits, 0 when unknown
  function automatic logic [4:0] fkey_num(input logic [7:0] hi, input logic [7:0] lo);
    fkey_num = 5'd0;
    case (hi)
      "1": begin
        case (lo)
          "1": fkey_num = 5'd1;
          "2": fkey_num = 5'd2;
          "3": fkey_num = 5'd3;
          "4": fkey_num = 5'd4;
          "5": fkey_num = 5'd5;
          "7": fkey_num = 5'd6;
          "8": fkey_num = 5'd7;
          "9": fkey_num = 5'd8;
          default: fkey_num = 5'd0;
        endcase
      end
      "2": begin
        case (lo)
          "0": fkey_num = 5'd9;
          "1": fkey_num = 5'd10;
          "3": fkey_num = 5'd11;
          "4": fkey_num = 5'd12;
          "5": fkey_num = 5'd13;
          "6": fkey_num = 5'd14;
          "8": fkey_num = 5'd15;
          "9": fkey_num = 5'd16;
          default: fkey_num = 5'd0;
        endcase
      end
      "3": begin
        case (lo)
          "1": fkey_num = 5'd17;
          "2": fkey_num = 5'd18;
          "3": fkey_num = 5'd19;
          "4": fkey_num = 5'd20;
          default: fkey_num = 5'd0;
        endcase
      end
      default: fkey_num = 5'd0;
    endcase
  endfunction

endpackage

>>> rtl/terminal_key_sequence_decoder.sv
// Throughput: one request per cycle while byte_stall is low; the decode is
// a single match on the stored bytes and the new byte, registered into a
// two-entry output stage (key_item and a skid entry).
// Reset (rst, synchronous): sequence and tick counter cleared, timeout 200,
// output stage empty. No clearing pass is needed.
module terminal_key_sequence_decoder
  import tksd_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  tksd_in_t    byte_item,
  output logic        key_valid,
  input  logic        key_stall,
  output tksd_out_t   key_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

  logic [7:0]                  seq_bytes [4];
  logic [2:0]                  seq_count;
  logic [2:0]                  seq_count_next;
  logic [TICK_COUNT_WIDTH-1:0] elapsed_ticks;
  logic [TICK_COUNT_WIDTH-1:0] elapsed_ticks_next;
  logic [TICK_COUNT_WIDTH-1:0] elapsed_inc;
  logic [15:0]                 timeout_ticks;

  tksd_out_t skid_item;
  logic      skid_valid;
  tksd_out_t res;

  logic       accept;
  logic       out_free;
  logic [7:0] b;
  logic [7:0] p;
  logic [4:0] fnum;
  logic [11:0] fc;
  logic [11:0] tc;

  assign cfg_ready  = 1'b1;
  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !byte_stall;
  assign out_free   = !key_valid || !key_stall;

  assign b    = byte_item.rx_byte;
  assign p    = seq_bytes[2];
  assign fc   = final_code(b);
  assign tc   = tilde_code(p);
  assign fnum = fkey_num(seq_bytes[2], seq_bytes[3]);
  assign elapsed_inc = (elapsed_ticks == {TICK_COUNT_WIDTH{1'b1}}) ?
                       elapsed_ticks : elapsed_ticks + 1'b1;

  always_comb begin
    res                = '{status: ST_UNK, key_code: 12'h000};
    seq_count_next     = 3'd0;
    elapsed_ticks_next = elapsed_ticks;
    case (byte_item.command)
      CMD_BYTE: begin
        elapsed_ticks_next = '0;
        case (seq_count)
          3'd0: begin
            if (b == CH_ESC || b == CH_UTF8) begin
              seq_count_next = 3'd1;
              res.status = ST_WAIT;
            end else if (b <= CH_ASCII_MAX) begin
              res = '{status: ST_KEY, key_code: {4'h0, b}};
            end
          end
          3'd1: begin
            if (seq_bytes[0] == CH_UTF8) begin
              if (b == CH_POUND) res = '{status: ST_KEY, key_code: CODE_GBP};
            end else if (b != "[") begin
              res = '{status: ST_KEY, key_code: {4'h0, b}};
            end else begin
              seq_count_next = 3'd2;
              res.status = ST_WAIT;
            end
          end
          3'd2: begin
            if (fc != 12'h000) begin
              res = '{status: ST_KEY, key_code: fc};
            end else if (b == "O" || (b >= "1" && b <= "6")) begin
              seq_count_next = 3'd3;
              res.status = ST_WAIT;
            end
          end
          3'd3: begin
            if (b == "~") begin
              if (tc != 12'h000) res = '{status: ST_KEY, key_code: tc};
            end else if (p == "O") begin
              if (b >= "P" && b <= "S")
                res = '{status: ST_KEY, key_code: CODE_FN | {9'd0, b[2:0] - 3'd7}};
            end else if ((p == "1" && b > "0" && b <= "9" && b != "6") ||
                         (p == "2" && b >= "0" && b <= "9" && b != "2" && b != "7") ||
                         (p == "3" && b > "0" && b <= "4")) begin
              seq_count_next = 3'd4;
              res.status = ST_WAIT;
            end
          end
          3'd4: begin
            if (b == "~" && fnum != 5'd0)
              res = '{status: ST_KEY, key_code: CODE_FN | {7'd0, fnum}};
          end
          default: res.status = ST_UNK;
        endcase
      end
      CMD_TICK: begin
        elapsed_ticks_next = elapsed_inc;
        if (seq_count == 3'd0) begin
          res.status = ST_NONE;
        end else if (CW'(elapsed_inc) < CW'(timeout_ticks)) begin
          seq_count_next = seq_count;
          res.status = ST_WAIT;
        end else if (seq_count == 3'd1) begin
          res = '{status: ST_KEY, key_code: {4'h0, seq_bytes[0]}};
        end else begin
          res.status = ST_TRUNC;
        end
      end
      default: res.status = ST_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && byte_item.command == CMD_BYTE && !seq_count[2])
      seq_bytes[seq_count[1:0]] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count     <= 3'd0;
      elapsed_ticks <= '0;
      timeout_ticks <= TIMEOUT_RESET;
      key_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_ticks <= cfg_data;
      if (accept) begin
        seq_count     <= seq_count_next;
        elapsed_ticks <= elapsed_ticks_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          key_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          key_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) key_item <= skid_item;
      else if (accept) key_item <= res;
    end else if (accept) begin
      skid_item <= res;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> key_valid)
    else $error("skid entry held without an output entry");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seq_count <= 3'd4)
    else $error("sequence count out of range");

  a_error_drops: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_item.command[1]) |=> (seq_count == 3'd0))
    else $error("read error did not drop the sequence");

  a_tick_keeps_bytes: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_item.command == CMD_TICK) |=> (seq_count <= $past(seq_count)))
    else $error("tick grew the sequence");
`endif

endmodule

>>> test/key_decode_checker.sv
`timescale 1ns / 100ps

module key_decode_checker
  import tksd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  tksd_in_t    byte_item,
  input  logic        key_valid,
  input  logic        key_stall,
  input  tksd_out_t   key_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          error_count,
  output int          pending_count
);

  logic [7:0]  held [4];
  logic [2:0]  held_cnt;
  logic [15:0] idle_ticks;
  logic [15:0] flush_ticks;
  tksd_out_t   expected_keys [$];
  int          fails = 0;

  function automatic logic [11:0] csi_final_key(input logic [7:0] b);
    case (b)
      "A": return 12'h102;
      "B": return 12'h104;
      "C": return 12'h101;
      "D": return 12'h108;
      "H": return 12'h118;
      "F": return 12'h111;
      default: return 12'h000;
    endcase
  endfunction

  function automatic logic [11:0] tilde_key(input logic [7:0] d);
    case (d)
      "1": return 12'h118;
      "2": return 12'h121;
      "3": return 12'h122;
      "4": return 12'h111;
      "5": return 12'h112;
      "6": return 12'h114;
      default: return 12'h000;
    endcase
  endfunction

  // F-key number from the two digits, 0 when not a key
  function automatic logic [4:0] fn_number(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] d;
    fn_number = 5'd0;
    if (lo >= "0" && lo <= "9") begin
      d = 5'(lo - "0");
      case (hi)
        "1": begin
          if (d >= 1 && d <= 5) fn_number = d;
          else if (d >= 7) fn_number = d - 5'd1;
        end
        "2": begin
          if (d <= 1) fn_number = d + 5'd9;
          else if (d >= 3 && d <= 6) fn_number = d + 5'd8;
          else if (d >= 8) fn_number = d + 5'd7;
        end
        "3": begin
          if (d >= 1 && d <= 4) fn_number = d + 5'd16;
        end
        default: fn_number = 5'd0;
      endcase
    end
  endfunction

  function automatic tksd_out_t decode_request(input tksd_in_t req);
    tksd_out_t   res;
    logic [7:0]  b;
    logic [7:0]  p;
    logic [2:0]  n;
    logic [11:0] c;
    logic [4:0]  fn;
    logic        ok;
    res.status = ST_UNK;
    res.key_code = '0;
    b = req.rx_byte;
    if (req.command == CMD_BYTE) begin
      n = held_cnt;
      idle_ticks = '0;
      if (n < 3'd4) held[n[1:0]] = b;
      held_cnt = 3'd0;
      case (n)
        3'd0: begin
          if (b == CH_ESC || b == CH_UTF8) begin
            held_cnt = 3'd1;
            res.status = ST_WAIT;
          end else if (b <= CH_ASCII_MAX) begin
            res.status = ST_KEY;
            res.key_code = {4'h0, b};
          end
        end
        3'd1: begin
          if (held[0] == CH_UTF8) begin
            if (b == CH_POUND) begin
              res.status = ST_KEY;
              res.key_code = CODE_GBP;
            end
          end else if (b != "[") begin
            res.status = ST_KEY;
            res.key_code = {4'h0, b};
          end else begin
            held_cnt = 3'd2;
            res.status = ST_WAIT;
          end
        end
        3'd2: begin
          c = csi_final_key(b);
          if (c != 12'h000) begin
            res.status = ST_KEY;
            res.key_code = c;
          end else if (b == "O" || (b >= "1" && b <= "6")) begin
            held_cnt = 3'd3;
            res.status = ST_WAIT;
          end
        end
        3'd3: begin
          p = held[2];
          if (b == "~") begin
            c = tilde_key(p);
            if (c != 12'h000) begin
              res.status = ST_KEY;
              res.key_code = c;
            end
          end else if (p == "O") begin
            if (b >= "P" && b <= "S") begin
              res.status = ST_KEY;
              res.key_code = CODE_FN | {4'h0, b - 8'("O")};
            end
          end else begin
            if (p == "1") ok = b > "0" && b <= "9" && b != "6";
            else if (p == "2") ok = b >= "0" && b <= "9" && b != "2" && b != "7";
            else if (p == "3") ok = b > "0" && b <= "4";
            else ok = 1'b0;
            if (ok) begin
              held_cnt = 3'd4;
              res.status = ST_WAIT;
            end
          end
        end
        3'd4: begin
          fn = fn_number(held[2], held[3]);
          if (b == "~" && fn != 5'd0) begin
            res.status = ST_KEY;
            res.key_code = CODE_FN | {7'd0, fn};
          end
        end
        default: res.status = ST_UNK;
      endcase
    end else if (req.command == CMD_TICK) begin
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
      if (held_cnt == 3'd0) begin
        res.status = ST_NONE;
      end else if (idle_ticks < flush_ticks) begin
        res.status = ST_WAIT;
      end else if (held_cnt == 3'd1) begin
        held_cnt = 3'd0;
        res.status = ST_KEY;
        res.key_code = {4'h0, held[0]};
      end else begin
        held_cnt = 3'd0;
        res.status = ST_TRUNC;
      end
    end else begin
      held_cnt = 3'd0;
      res.status = ST_ERR;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    tksd_out_t want;
    if (rst) begin
      held_cnt = 3'd0;
      idle_ticks = '0;
      flush_ticks = TIMEOUT_RESET;
      expected_keys.delete();
    end else begin
      if (key_valid && !key_stall) begin
        if (expected_keys.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected key result: status %0d code %h",
                     key_item.status, key_item.key_code);
        end else begin
          want = expected_keys.pop_front();
          if (key_item.status !== want.status || key_item.key_code !== want.key_code) begin
            fails++;
            if (fails <= 10)
              $display("key mismatch: expected status %0d code %h, got status %0d code %h",
                       want.status, want.key_code, key_item.status, key_item.key_code);
          end
        end
      end
      if (cfg_valid && cfg_ready) flush_ticks = cfg_data;
      if (byte_valid && !byte_stall) expected_keys.push_back(decode_request(byte_item));
    end
    error_count <= fails;
    pending_count <= expected_keys.size();
  end

endmodule

>>> test/terminal_key_sequence_decoder_tb.sv
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_tb;
  import tksd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_REQS  = 580;
  localparam logic [1:0] CMD_READ_ERR = 2'd2;
  localparam logic [1:0] CMD_SPARE    = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  tksd_in_t    byte_item;
  logic        key_valid;
  logic        key_stall = 1'b0;
  tksd_out_t   key_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int   error_count;
  int   pending_count;
  int   cycles = 0;
  int   reqs_sent = 0;
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;

  always #5 clk = ~clk;

  terminal_key_sequence_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_item   (key_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  key_decode_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_item     (byte_item),
    .key_valid     (key_valid),
    .key_stall     (key_stall),
    .key_item      (key_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // receiver: random stall, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      key_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      key_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [7:0] b);
    tksd_in_t req;
    req.command = cmd;
    req.rx_byte = b;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= req;
    do @(posedge clk); while (byte_stall);
    reqs_sent++;
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] ticks);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one key sequence, whole, cut short by ticks, broken, or plain noise
  task automatic send_burst(input int tmo);
    logic [7:0] keys [$];
    logic [7:0] hi;
    logic [7:0] lo;
    string      finals;
    int         kind;
    int         cut;
    int         ticks;
    finals = "ABCDHF";
    case ($urandom_range(0, 6))
      0: keys.push_back(8'($urandom_range(0, 127)));
      1: begin
        keys.push_back(CH_ESC);
        keys.push_back("[");
        keys.push_back(finals[$urandom_range(0, 5)]);
      end
      2: begin
        keys.push_back(CH_ESC);
        keys.push_back("[");
        keys.push_back(8'("0") + 8'($urandom_range(1, 6)));
        keys.push_back("~");
      end
      3: begin
        keys.push_back(CH_ESC);
        keys.push_back("[");
        keys.push_back("O");
        keys.push_back(8'("P") + 8'($urandom_range(0, 3)));
      end
      4: begin
        hi = 8'("0") + 8'($urandom_range(1, 3));
        do lo = 8'("0") + 8'($urandom_range(0, 9));
        while ((hi == "1" && (lo == "0" || lo == "6")) ||
               (hi == "2" && (lo == "2" || lo == "7")) ||
               (hi == "3" && (lo < "1" || lo > "4")));
        keys.push_back(CH_ESC);
        keys.push_back("[");
        keys.push_back(hi);
        keys.push_back(lo);
        keys.push_back("~");
      end
      5: begin
        keys.push_back(CH_UTF8);
        keys.push_back(CH_POUND);
      end
      default: begin
        keys.push_back(CH_ESC);
        lo = 8'($urandom_range(0, 255));
        keys.push_back(lo == "[" ? 8'("x") : lo);
      end
    endcase
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      foreach (keys[i]) send_req(CMD_BYTE, keys[i]);
    end else if (kind < 80 && keys.size() > 1) begin
      cut = $urandom_range(1, keys.size() - 1);
      for (int i = 0; i < cut; i++) send_req(CMD_BYTE, keys[i]);
      ticks = $urandom_range(1, tmo + 2);
      repeat (ticks) send_req(CMD_TICK, 8'($urandom_range(0, 255)));
      if (ticks < tmo && $urandom_range(0, 1))
        for (int i = cut; i < keys.size(); i++) send_req(CMD_BYTE, keys[i]);
    end else if (kind < 90 && keys.size() > 1) begin
      cut = $urandom_range(1, keys.size() - 1);
      for (int i = 0; i < cut; i++) send_req(CMD_BYTE, keys[i]);
      send_req(CMD_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4))
        send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int tmo);
    int start;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    start = reqs_sent;
    while (reqs_sent - start < PHASE_REQS) send_burst(tmo);
  endtask

  initial begin
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_timeout(16'd2);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_BYTE, CH_ASCII_MAX);
    send_req(CMD_BYTE, 8'hFF);
    send_req(CMD_BYTE, CH_ESC);
    send_req(CMD_BYTE, "[");
    send_req(CMD_BYTE, "A");
    send_req(CMD_BYTE, CH_UTF8);
    send_req(CMD_BYTE, CH_POUND);
    send_req(CMD_BYTE, CH_ESC);
    send_req(CMD_BYTE, "x");
    send_req(CMD_BYTE, CH_ESC);
    send_req(CMD_BYTE, "[");
    send_req(CMD_BYTE, "Z");
    send_req(CMD_TICK, 8'h00);
    // lone ESC flushed by silence, then a cut-off CSI
    send_req(CMD_BYTE, CH_ESC);
    send_req(CMD_TICK, 8'hFF);
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_BYTE, CH_ESC);
    send_req(CMD_BYTE, "[");
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_TICK, 8'h00);
    send_req(CMD_READ_ERR, 8'h00);
    send_req(CMD_BYTE, CH_ESC);
    send_req(CMD_SPARE, 8'hFF);

    set_timeout(16'd1);
    hold_req <= 1'b1;
    run_phase(22, 58, 1);
    set_timeout(16'd9);
    run_phase(58, 22, 9);
    set_timeout(16'd0);
    run_phase(0, 0, 0);

    // longest timeout: a partial sequence keeps waiting through the silence
    set_timeout(16'hFFFF);
    send_req(CMD_BYTE, CH_ESC);
    repeat (16) send_req(CMD_TICK, 8'h00);
    send_req(CMD_READ_ERR, 8'h00);

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
